FILE: rtl/core/acwu_pkg.sv
`default_nettype none

package acwu_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ANG_W = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_NEAR     = 2'd0;
    localparam logic [1:0] OP_SECTION  = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;

    localparam logic [1:0] SEC_NEUTRAL = 2'd0;
    localparam logic [1:0] SEC_CW      = 2'd1;
    localparam logic [1:0] SEC_CCW     = 2'd2;
    localparam logic [1:0] SEC_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_LOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CW_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CW_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CCW_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CCW_HIGH    = 3'd7;

    localparam logic signed [ANG_W-1:0] RST_AXIS_LOW     = -20'sd49152;
    localparam logic signed [ANG_W-1:0] RST_AXIS_HIGH    = 20'sd49152;
    localparam logic signed [ANG_W-1:0] RST_NEUTRAL_LOW  = -20'sd16384;
    localparam logic signed [ANG_W-1:0] RST_NEUTRAL_HIGH = 20'sd16384;
    localparam logic signed [ANG_W-1:0] RST_CW_LOW       = 20'sd16384;
    localparam logic signed [ANG_W-1:0] RST_CW_HIGH      = 20'sd49152;
    localparam logic signed [ANG_W-1:0] RST_CCW_LOW      = -20'sd49152;
    localparam logic signed [ANG_W-1:0] RST_CCW_HIGH     = -20'sd16384;

    typedef struct packed {
        logic signed [ANG_W-1:0] axis_low;
        logic signed [ANG_W-1:0] axis_high;
        logic signed [ANG_W-1:0] neutral_low;
        logic signed [ANG_W-1:0] neutral_high;
        logic signed [ANG_W-1:0] cw_low;
        logic signed [ANG_W-1:0] cw_high;
        logic signed [ANG_W-1:0] ccw_low;
        logic signed [ANG_W-1:0] ccw_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [ANG_W-1:0] az_in;
        logic signed [ANG_W-1:0] prev_az;
        logic [1:0]              section;
    } req_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] az_out;
        logic                    out_of_section;
        logic [1:0]              wrap_section;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/acwu_resolve.sv
`default_nettype none

module acwu_resolve #(
    parameter int ANGLE_FRAC_BITS = acwu_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire acwu_pkg::cfg_t cfg,
    input  wire acwu_pkg::req_t req,
    output acwu_pkg::res_t      res
);

    localparam int AW = acwu_pkg::ANG_W;
    localparam int F  = ANGLE_FRAC_BITS;
    localparam int IW = F + 24;
    localparam logic signed [IW-1:0] ONE  = IW'(1);
    localparam logic signed [IW-1:0] TURN = ONE <<< F;
    localparam logic signed [IW-1:0] HALF = ONE <<< (F - 1);
    localparam logic signed [IW-1:0] MASK = TURN - ONE;
    localparam logic signed [IW-1:0] SAT_MAX = {{(IW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [IW-1:0] SAT_MIN = {{(IW-AW+1){1'b1}}, {(AW-1){1'b0}}};

    logic signed [IW-1:0] az_x, prev_x, alo_x, ahi_x;
    logic signed [IW-1:0] diff, a, nn, kk, res0;
    logic signed [AW-1:0] lo, hi;
    logic signed [IW-1:0] lo_x, hi_x, e, m, res1;
    logic signed [IW-1:0] exact;
    logic                 flag;
    logic signed [AW-1:0] sat;

    assign az_x   = {{(IW-AW){req.az_in[AW-1]}}, req.az_in};
    assign prev_x = {{(IW-AW){req.prev_az[AW-1]}}, req.prev_az};
    assign alo_x  = {{(IW-AW){cfg.axis_low[AW-1]}}, cfg.axis_low};
    assign ahi_x  = {{(IW-AW){cfg.axis_high[AW-1]}}, cfg.axis_high};

    // nearest turn to previous azimuth within the axis travel
    always_comb begin
        diff = az_x - alo_x;
        a    = alo_x + (diff & MASK);
        nn   = (ahi_x - a) >>> F;
        if (nn < 0) begin
            nn = '0;
        end
        kk = (prev_x - a + HALF) >>> F;
        if (kk > nn) begin
            kk = nn;
        end
        if (kk < 0) begin
            kk = '0;
        end
        res0 = a + (kk <<< F);
    end

    always_comb begin
        case (req.section)
            acwu_pkg::SEC_NEUTRAL: begin
                lo = cfg.neutral_low;
                hi = cfg.neutral_high;
            end
            acwu_pkg::SEC_CW: begin
                lo = cfg.cw_low;
                hi = cfg.cw_high;
            end
            default: begin
                lo = cfg.ccw_low;
                hi = cfg.ccw_high;
            end
        endcase
    end

    // wrap next to the doubled section centre
    always_comb begin
        lo_x = {{(IW-AW){lo[AW-1]}}, lo};
        hi_x = {{(IW-AW){hi[AW-1]}}, hi};
        e    = (az_x <<< 1) - (lo_x + hi_x);
        m    = (e + TURN - ONE) >>> (F + 1);
        res1 = az_x - (m <<< F);
    end

    always_comb begin
        exact = az_x;
        flag  = 1'b0;
        case (req.op)
            acwu_pkg::OP_NEAR: begin
                exact = res0;
            end
            acwu_pkg::OP_SECTION: begin
                if (req.section != acwu_pkg::SEC_NONE) begin
                    exact = res1;
                    flag  = (res1 > hi_x) || (res1 < lo_x);
                end
            end
            default: begin
                exact = az_x;
            end
        endcase
        if (exact > SAT_MAX) begin
            sat = SAT_MAX[AW-1:0];
        end else if (exact < SAT_MIN) begin
            sat = SAT_MIN[AW-1:0];
        end else begin
            sat = exact[AW-1:0];
        end
    end

    always_comb begin
        res.az_out         = sat;
        res.out_of_section = flag;
        if (sat <= cfg.neutral_high && sat >= cfg.neutral_low) begin
            res.wrap_section = acwu_pkg::SEC_NEUTRAL;
        end else if (sat <= cfg.cw_high && sat >= cfg.cw_low) begin
            res.wrap_section = acwu_pkg::SEC_CW;
        end else if (sat <= cfg.ccw_high && sat >= cfg.ccw_low) begin
            res.wrap_section = acwu_pkg::SEC_CCW;
        end else begin
            res.wrap_section = acwu_pkg::SEC_NEUTRAL;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/azimuth_cable_wrap_unwrap.sv
// Azimuth cable-wrap resolver.
// Input stream s_axis_*: one request per accepted beat carries op and section in
// tuser and az_in / prev_az in tdata. Result stream m_axis_*: one result per
// request, az_out in tdata, out_of_section and wrap_section in tuser.
// Section and axis limits are loaded through cfg_wr_en / cfg_index / cfg_data,
// one register per cycle; the user must load them only while no request
// is in flight, as the block itself does not enforce it. A request held in the
// input register moves to the result register when that stage can advance.
// Throughput: one request per cycle while m_axis does not stall; both stages
// are registers; the resolve logic sits between them.
// Reset (aresetn low, synchronous): both stages empty, limits back to their
// defaults (axis +/-0.75 turn, neutral +/-0.25 turn, cw and ccw beyond).
// A stalled receiver holds the result register; the input register still
// takes one more request, after which s_axis_tready drops until m_axis drains.
`default_nettype none

module azimuth_cable_wrap_unwrap #(
    parameter int ANGLE_FRAC_BITS = acwu_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [19:0] cfg_data,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // az_in [19:0], prev_az [39:20]
    input  wire  [3:0]  s_axis_tuser,   // op [1:0], section [3:2]

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // az_out [19:0], zero [23:20]
    output logic [2:0]  m_axis_tuser    // out_of_section [0], wrap_section [2:1]
);

    acwu_pkg::cfg_t cfg_reg;
    acwu_pkg::req_t req_reg;
    acwu_pkg::res_t res_reg;
    acwu_pkg::res_t res_next;
    logic           req_vld_reg;
    logic           res_vld_reg;
    logic           req_vld_next;
    logic           res_vld_next;
    logic           adv;
    logic           take;

    assign adv           = !res_vld_reg || m_axis_tready;
    assign s_axis_tready = !req_vld_reg || adv;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        req_vld_next = req_vld_reg;
        res_vld_next = res_vld_reg;
        if (adv) begin
            res_vld_next = req_vld_reg;
            req_vld_next = take;
        end else if (take) begin
            req_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_low     <= acwu_pkg::RST_AXIS_LOW;
            cfg_reg.axis_high    <= acwu_pkg::RST_AXIS_HIGH;
            cfg_reg.neutral_low  <= acwu_pkg::RST_NEUTRAL_LOW;
            cfg_reg.neutral_high <= acwu_pkg::RST_NEUTRAL_HIGH;
            cfg_reg.cw_low       <= acwu_pkg::RST_CW_LOW;
            cfg_reg.cw_high      <= acwu_pkg::RST_CW_HIGH;
            cfg_reg.ccw_low      <= acwu_pkg::RST_CCW_LOW;
            cfg_reg.ccw_high     <= acwu_pkg::RST_CCW_HIGH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                acwu_pkg::REG_AXIS_LOW:     cfg_reg.axis_low     <= cfg_data;
                acwu_pkg::REG_AXIS_HIGH:    cfg_reg.axis_high    <= cfg_data;
                acwu_pkg::REG_NEUTRAL_LOW:  cfg_reg.neutral_low  <= cfg_data;
                acwu_pkg::REG_NEUTRAL_HIGH: cfg_reg.neutral_high <= cfg_data;
                acwu_pkg::REG_CW_LOW:       cfg_reg.cw_low       <= cfg_data;
                acwu_pkg::REG_CW_HIGH:      cfg_reg.cw_high      <= cfg_data;
                acwu_pkg::REG_CCW_LOW:      cfg_reg.ccw_low      <= cfg_data;
                acwu_pkg::REG_CCW_HIGH:     cfg_reg.ccw_high     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            req_vld_reg <= req_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg.op      <= s_axis_tuser[1:0];
            req_reg.section <= s_axis_tuser[3:2];
            req_reg.az_in   <= s_axis_tdata[19:0];
            req_reg.prev_az <= s_axis_tdata[39:20];
        end
        if (adv && req_vld_reg) begin
            res_reg <= res_next;
        end
    end

    acwu_resolve #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_resolve (
        .cfg(cfg_reg),
        .req(req_reg),
        .res(res_next)
    );

    assign m_axis_tvalid = res_vld_reg;
    assign m_axis_tdata  = {4'b0000, res_reg.az_out};
    assign m_axis_tuser  = {res_reg.wrap_section, res_reg.out_of_section};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        req_vld_reg && adv |=> m_axis_tvalid)
        else $error("request lost between stages");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> req_vld_reg && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    a_section_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser[2:1] != acwu_pkg::SEC_NONE)
        else $error("wrap section code out of range");

endmodule

`default_nettype wire

FILE: tb/tb_azimuth_cable_wrap_unwrap.sv
`timescale 1ns / 100ps

module tb_azimuth_cable_wrap_unwrap;

    localparam int     FRAC = acwu_pkg::ANGLE_FRAC_BITS_DEF;
    localparam longint TURN = longint'(1) << FRAC;
    localparam longint AZ_MAX = 524287;
    localparam longint AZ_MIN = -524288;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [acwu_pkg::CFG_IDX_W-1:0] REG_ORDER [8] = '{
        acwu_pkg::REG_AXIS_LOW, acwu_pkg::REG_AXIS_HIGH,
        acwu_pkg::REG_NEUTRAL_LOW, acwu_pkg::REG_NEUTRAL_HIGH,
        acwu_pkg::REG_CW_LOW, acwu_pkg::REG_CW_HIGH,
        acwu_pkg::REG_CCW_LOW, acwu_pkg::REG_CCW_HIGH
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // az_in [19:0], prev_az [39:20]
    logic [3:0]  s_axis_tuser = '0;   // op [1:0], section [3:2]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;        // az_out [19:0], zero [23:20]
    wire  [2:0]  m_axis_tuser;        // out_of_section [0], wrap_section [2:1]

    azimuth_cable_wrap_unwrap u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    acwu_pkg::cfg_t limits;
    acwu_pkg::req_t request_q [$];
    acwu_pkg::res_t pending_results [$];
    acwu_pkg::req_t offered;
    acwu_pkg::res_t want;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_armed = 1'b0;
    bit   hold_used = 1'b0;
    int   hold_left = 0;
    int   fail_cnt = 0;

    function automatic longint sx(logic signed [acwu_pkg::ANG_W-1:0] v);
        return longint'(v);
    endfunction

    function automatic logic [1:0] wrap_of(longint v);
        if (v <= sx(limits.neutral_high) && v >= sx(limits.neutral_low))
            return acwu_pkg::SEC_NEUTRAL;
        if (v <= sx(limits.cw_high) && v >= sx(limits.cw_low))
            return acwu_pkg::SEC_CW;
        if (v <= sx(limits.ccw_high) && v >= sx(limits.ccw_low))
            return acwu_pkg::SEC_CCW;
        return acwu_pkg::SEC_NEUTRAL;
    endfunction

    function automatic acwu_pkg::res_t resolve_azimuth(acwu_pkg::req_t r);
        longint az, prev, lo, hi, a, n, k, e, m, res;
        acwu_pkg::res_t o;
        az = sx(r.az_in);
        prev = sx(r.prev_az);
        res = az;
        o.out_of_section = 1'b0;
        if (r.op == acwu_pkg::OP_NEAR) begin
            a = sx(limits.axis_low) + ((az - sx(limits.axis_low)) & (TURN - 1));
            n = (sx(limits.axis_high) - a) >>> FRAC;
            k = (prev - a + TURN / 2) >>> FRAC;
            if (n < 0) n = 0;
            if (k > n) k = n;
            if (k < 0) k = 0;
            res = a + k * TURN;
        end else if (r.op == acwu_pkg::OP_SECTION && r.section != acwu_pkg::SEC_NONE) begin
            case (r.section)
                acwu_pkg::SEC_NEUTRAL: begin
                    lo = sx(limits.neutral_low);
                    hi = sx(limits.neutral_high);
                end
                acwu_pkg::SEC_CW: begin
                    lo = sx(limits.cw_low);
                    hi = sx(limits.cw_high);
                end
                default: begin
                    lo = sx(limits.ccw_low);
                    hi = sx(limits.ccw_high);
                end
            endcase
            e = 2 * az - (lo + hi);
            m = (e + TURN - 1) >>> (FRAC + 1);
            res = az - m * TURN;
            o.out_of_section = (res > hi || res < lo);
        end
        if (res > AZ_MAX) res = AZ_MAX;
        if (res < AZ_MIN) res = AZ_MIN;
        o.az_out = res[acwu_pkg::ANG_W-1:0];
        o.wrap_section = wrap_of(res);
        return o;
    endfunction

    function automatic acwu_pkg::req_t random_request();
        acwu_pkg::req_t r;
        int   sel;
        sel = $urandom_range(99);
        if (sel < 40) r.op = acwu_pkg::OP_NEAR;
        else if (sel < 80) r.op = acwu_pkg::OP_SECTION;
        else if (sel < 95) r.op = acwu_pkg::OP_CLASSIFY;
        else r.op = OP_SPARE;
        sel = $urandom_range(9);
        if (sel < 5) r.az_in = 20'($urandom);
        else if (sel < 9) r.az_in = 20'($urandom_range(0, 262143) - 131072);
        else begin
            case ($urandom_range(3))
                0: r.az_in = 20'sh80000;
                1: r.az_in = 20'sh7FFFF;
                2: r.az_in = '0;
                default: r.az_in = '1;
            endcase
        end
        if ($urandom_range(9) < 7)
            r.prev_az = r.az_in + 20'($urandom_range(0, 393216) - 196608);
        else
            r.prev_az = 20'($urandom);
        r.section = 2'($urandom_range(3));
        return r;
    endfunction

    function automatic acwu_pkg::cfg_t random_limits(bit wild);
        acwu_pkg::cfg_t c;
        int   ctr, w;
        if (wild) begin
            c = {8{20'($urandom)}};
            c.axis_low = 20'($urandom);
            c.axis_high = 20'($urandom);
            c.neutral_low = 20'($urandom);
            c.neutral_high = 20'($urandom);
            c.cw_low = 20'($urandom);
            c.cw_high = 20'($urandom);
            c.ccw_low = 20'($urandom);
            c.ccw_high = 20'($urandom);
        end else begin
            ctr = $urandom_range(0, 400000) - 200000;
            c.axis_low = 20'(ctr - int'($urandom_range(0, 150000)));
            c.axis_high = 20'(ctr + int'($urandom_range(0, 150000)) - 10000);
            w = $urandom_range(1000, 60000);
            c.neutral_low = 20'(ctr - w);
            c.neutral_high = 20'(ctr + w);
            c.cw_low = 20'(ctr + w + 1);
            c.cw_high = 20'(ctr + w + int'($urandom_range(0, 80000)));
            c.ccw_low = 20'(ctr - w - int'($urandom_range(0, 80000)));
            c.ccw_high = 20'(ctr - w - 1);
        end
        return c;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(resolve_azimuth(offered));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered.prev_az, offered.az_in};
                    s_axis_tuser <= {offered.section, offered.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: az_out %0d",
                           $signed(m_axis_tdata[19:0]));
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[19:0] !== want.az_out) begin
                        $error("az_out: expected %0d, got %0d",
                               want.az_out, $signed(m_axis_tdata[19:0]));
                        fail_cnt++;
                    end
                    if (m_axis_tuser[0] !== want.out_of_section) begin
                        $error("out_of_section: expected %0d, got %0d",
                               want.out_of_section, m_axis_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser[2:1] !== want.wrap_section) begin
                        $error("wrap_section: expected %0d, got %0d",
                               want.wrap_section, m_axis_tuser[2:1]);
                        fail_cnt++;
                    end
                end
            end
            if (hold_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic queue_request(logic [1:0] op, int az, int prev, logic [1:0] sec);
        acwu_pkg::req_t r;
        r.op = op;
        r.az_in = 20'(az);
        r.prev_az = 20'(prev);
        r.section = sec;
        request_q.push_back(r);
    endtask

    task automatic load_limits(acwu_pkg::cfg_t c);
        logic [19:0] v [8];
        v = '{c.axis_low, c.axis_high, c.neutral_low, c.neutral_high,
              c.cw_low, c.cw_high, c.ccw_low, c.ccw_high};
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= v[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limits = c;
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            request_q.push_back(random_request());
        @(negedge aclk);
        while (request_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        acwu_pkg::cfg_t c;
        limits = '{acwu_pkg::RST_AXIS_LOW, acwu_pkg::RST_AXIS_HIGH,
                   acwu_pkg::RST_NEUTRAL_LOW, acwu_pkg::RST_NEUTRAL_HIGH,
                   acwu_pkg::RST_CW_LOW, acwu_pkg::RST_CW_HIGH,
                   acwu_pkg::RST_CCW_LOW, acwu_pkg::RST_CCW_HIGH};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults after reset: ties, section edges, none, spare op
        queue_request(acwu_pkg::OP_NEAR, 0, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_NEAR, -40000, -7232, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_NEAR, -40000, -7233, acwu_pkg::SEC_CCW);
        queue_request(acwu_pkg::OP_NEAR, 524287, -524288, acwu_pkg::SEC_NONE);
        queue_request(acwu_pkg::OP_NEAR, -524288, 524287, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_SECTION, 32768, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_SECTION, -32768, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_SECTION, -500000, 1, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_SECTION, 500000, -1, acwu_pkg::SEC_CCW);
        queue_request(acwu_pkg::OP_SECTION, 123456, 77, acwu_pkg::SEC_NONE);
        queue_request(acwu_pkg::OP_CLASSIFY, 16384, 0, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_CLASSIFY, 16385, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_CLASSIFY, -49153, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(OP_SPARE, -16385, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(OP_SPARE, 524287, -524288, acwu_pkg::SEC_NONE);
        run_phase(70, 0, 0);

        c.axis_low = -20'sd100000;
        c.axis_high = 20'sd200000;
        c.neutral_low = -20'sd30000;
        c.neutral_high = 20'sd30000;
        c.cw_low = 20'sd30001;
        c.cw_high = 20'sd150000;
        c.ccw_low = -20'sd100000;
        c.ccw_high = -20'sd30001;
        load_limits(c);
        run_phase(70, 68, 0);

        // widest axis; point neutral and cw at the range ends, full-range ccw
        c.axis_low = 20'sh80000;
        c.axis_high = 20'sh7FFFF;
        c.neutral_low = 20'sh80000;
        c.neutral_high = 20'sh80000;
        c.cw_low = 20'sh7FFFF;
        c.cw_high = 20'sh7FFFF;
        c.ccw_low = 20'sh80000;
        c.ccw_high = 20'sh7FFFF;
        load_limits(c);
        queue_request(acwu_pkg::OP_SECTION, 524287, 0, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_SECTION, -524288, 0, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_SECTION, 20000, 0, acwu_pkg::SEC_CW);
        queue_request(acwu_pkg::OP_SECTION, 524287, 0, acwu_pkg::SEC_NEUTRAL);
        queue_request(acwu_pkg::OP_NEAR, 524287, 524287, acwu_pkg::SEC_NONE);
        run_phase(70, 0, 68);

        // inverted axis, neutral and cw sections: no offset, saturation on op 0
        c.axis_low = 20'sh7FFFF;
        c.axis_high = 20'sh80000;
        c.neutral_low = 20'sd16384;
        c.neutral_high = -20'sd16384;
        c.cw_low = 20'sh7FFFF;
        c.cw_high = 20'sh80000;
        c.ccw_low = '0;
        c.ccw_high = '0;
        load_limits(c);
        run_phase(70, 9, 9);

        // receiver holds off while requests keep coming
        load_limits(random_limits(1'b0));
        hold_armed = 1'b1;
        run_phase(70, 0, 0);

        load_limits(random_limits(1'b1));
        run_phase(70, 9, 9);

        load_limits(random_limits(1'b0));
        run_phase(70, 68, 68);

        repeat (8) @(posedge aclk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
